// ----- rtl/core/dsha_pkg.sv -----
// ----------------------------------------------------------------------------
// dsha_pkg
// Shared types and constants for the double SHA-256 core: round constants,
// initial hash value, request codes and the controller/datapath command bus.
// ----------------------------------------------------------------------------
`default_nettype none

package dsha_pkg;

   // request kinds carried in req_tuser[1:0]
   localparam logic [1:0] REQ_ABSORB        = 2'd0;
   localparam logic [1:0] REQ_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] REQ_FINISH        = 2'd2;
   localparam logic [1:0] REQ_RESERVED      = 2'd3;

   // last fill level that still leaves room for the length in the same block
   localparam logic [5:0] FILL_LEN_MAX = 6'd55;
   localparam logic [5:0] FILL_LAST    = 6'd63;

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // where the 16 message words of a compression come from
   typedef enum logic [1:0] {
      SRC_BUF  = 2'd0,   // block buffer as is
      SRC_PAD1 = 2'd1,   // buffer padded, length if it fits
      SRC_PAD2 = 2'd2,   // extra block: zeros and length
      SRC_DIG  = 2'd3    // first digest padded for the second hash
   } src_type;

   typedef enum logic [1:0] {
      INIT_CHAIN = 2'd0,
      INIT_TMP   = 2'd1,
      INIT_IV    = 2'd2
   } init_type;

   typedef enum logic {
      DEST_CHAIN = 1'b0,
      DEST_TMP   = 1'b1
   } dest_type;

   typedef enum logic {
      COPY_TO_RUN  = 1'b0,
      COPY_TO_BASE = 1'b1
   } copy_dir_type;

   typedef struct packed {
      logic         load_iv;
      logic         copy_start;
      copy_dir_type copy_dir;
      logic         absorb;
      logic [7:0]   data;
      logic         comp_start;
      src_type      comp_src;
      init_type     comp_init;
      dest_type     comp_dest;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic [5:0] fill;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/dsha_dp.sv -----
// ----------------------------------------------------------------------------
// dsha_dp
// Datapath: running and base contexts, block buffers, copy sweep and the
// iterative SHA-256 compression unit (one round per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module dsha_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  dsha_pkg::cmd_type    cmd,
   output dsha_pkg::sts_type    sts,
   output logic [255:0]         rsp_data
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // contexts
   logic [31:0] hash_ff [8];
   logic [31:0] base_hash_ff [8];
   logic [31:0] tmp_ff [8];
   logic [31:0] ihv_ff [8];
   logic [31:0] wv_ff [8];
   logic [31:0] win_ff [16];
   logic [5:0]  fill_ff;
   logic [60:0] count_ff;
   logic [5:0]  base_fill_ff;
   logic [60:0] base_count_ff;

   // buffers, one 32-bit big-endian word per entry
   logic [31:0] run_mem [16];
   logic [31:0] base_mem [16];
   logic [31:0] run_rd_ff;
   logic [31:0] base_rd_ff;
   logic [3:0]  ra_ff;

   // sequencing
   logic                   copy_act_ff;
   dsha_pkg::copy_dir_type copy_dir_ff;
   logic                   comp_act_ff;
   logic                   comp_ld_ff;
   logic                   comp_fin_ff;
   logic [4:0]             step_ff;
   logic [5:0]             rnd_ff;
   dsha_pkg::src_type      src_ff;
   dsha_pkg::dest_type     dest_ff;
   logic [255:0]           rsp_ff;

   logic [3:0]  rd_addr;
   logic        step_wr;
   logic [31:0] init_vec [8];
   logic [31:0] load_word;
   logic [31:0] sched_new;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [63:0] bit_len;
   logic [4:0]  lane_lsb;

   assign rd_addr  = step_ff[3:0];
   assign step_wr  = (step_ff != 5'd0);
   assign bit_len  = {count_ff, 3'b000};
   assign lane_lsb = {~fill_ff[1:0], 3'b000};

   // start value of a compression
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         case (cmd.comp_init)
            dsha_pkg::INIT_CHAIN: init_vec[i] = hash_ff[i];
            dsha_pkg::INIT_TMP:   init_vec[i] = tmp_ff[i];
            dsha_pkg::INIT_IV:    init_vec[i] = dsha_pkg::IV_TABLE[i];
            default:              init_vec[i] = dsha_pkg::IV_TABLE[i];
         endcase
      end
   end

   // message word for the word index just read
   always_comb begin
      logic [5:0] pos;
      logic [7:0] byte_v;
      load_word = '0;
      pos       = '0;
      byte_v    = '0;
      case (src_ff)
         dsha_pkg::SRC_BUF: begin
            load_word = run_rd_ff;
         end
         dsha_pkg::SRC_PAD1: begin
            for (int b = 0; b < 4; b++) begin
               pos = {ra_ff, 2'(b)};
               if (pos < fill_ff) byte_v = run_rd_ff[8*(3-b) +: 8];
               else if (pos == fill_ff) byte_v = 8'h80;
               else byte_v = 8'h00;
               load_word[8*(3-b) +: 8] = byte_v;
            end
            if (fill_ff <= dsha_pkg::FILL_LEN_MAX) begin
               if (ra_ff == 4'd14) load_word = bit_len[63:32];
               if (ra_ff == 4'd15) load_word = bit_len[31:0];
            end
         end
         dsha_pkg::SRC_PAD2: begin
            if (ra_ff == 4'd14) load_word = bit_len[63:32];
            if (ra_ff == 4'd15) load_word = bit_len[31:0];
         end
         dsha_pkg::SRC_DIG: begin
            if (!ra_ff[3]) load_word = tmp_ff[ra_ff[2:0]];
            else if (ra_ff == 4'd8) load_word = 32'h8000_0000;
            else if (ra_ff == 4'd15) load_word = 32'h0000_0100;
         end
         default: load_word = '0;
      endcase
   end

   // one round and the next schedule word
   always_comb begin
      logic [31:0] s1, s0, ch, maj;
      s1 = rotr(wv_ff[4], 6) ^ rotr(wv_ff[4], 11) ^ rotr(wv_ff[4], 25);
      ch = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      s0 = rotr(wv_ff[0], 2) ^ rotr(wv_ff[0], 13) ^ rotr(wv_ff[0], 22);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1 = wv_ff[7] + s1 + ch + dsha_pkg::K_TABLE[rnd_ff] + win_ff[0];
      t2 = s0 + maj;
      sched_new = (rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10))
                + win_ff[9]
                + (rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3))
                + win_ff[0];
   end

   // buffer memories, registered reads
   always_ff @(posedge clock) begin
      run_rd_ff  <= run_mem[rd_addr];
      base_rd_ff <= base_mem[rd_addr];
      ra_ff      <= rd_addr;
      if (cmd.absorb) begin
         run_mem[fill_ff[5:2]][lane_lsb +: 8] <= cmd.data;
      end else if (copy_act_ff && step_wr && copy_dir_ff == dsha_pkg::COPY_TO_RUN) begin
         run_mem[ra_ff] <= base_rd_ff;
      end
      if (copy_act_ff && step_wr && copy_dir_ff == dsha_pkg::COPY_TO_BASE) begin
         base_mem[ra_ff] <= run_rd_ff;
      end
   end

   // control and context state
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_act_ff   <= 1'b0;
         comp_act_ff   <= 1'b0;
         comp_ld_ff    <= 1'b0;
         comp_fin_ff   <= 1'b0;
         step_ff       <= '0;
         rnd_ff        <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         base_fill_ff  <= '0;
         base_count_ff <= '0;
         hash_ff       <= dsha_pkg::IV_TABLE;
         base_hash_ff  <= dsha_pkg::IV_TABLE;
      end else begin
         // context loads and saves
         if (cmd.load_iv) begin
            hash_ff  <= dsha_pkg::IV_TABLE;
            fill_ff  <= '0;
            count_ff <= '0;
         end
         if (cmd.copy_start) begin
            copy_act_ff <= 1'b1;
            copy_dir_ff <= cmd.copy_dir;
            step_ff     <= '0;
            if (cmd.copy_dir == dsha_pkg::COPY_TO_RUN) begin
               hash_ff  <= base_hash_ff;
               fill_ff  <= base_fill_ff;
               count_ff <= base_count_ff;
            end else begin
               base_hash_ff  <= hash_ff;
               base_fill_ff  <= fill_ff;
               base_count_ff <= count_ff;
            end
         end else if (copy_act_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd16) copy_act_ff <= 1'b0;
         end
         if (cmd.absorb) begin
            fill_ff  <= fill_ff + 6'd1;
            count_ff <= count_ff + 61'd1;
         end

         // compression sequencing
         if (cmd.comp_start) begin
            comp_act_ff <= 1'b1;
            comp_ld_ff  <= 1'b1;
            step_ff     <= '0;
            rnd_ff      <= '0;
            src_ff      <= cmd.comp_src;
            dest_ff     <= cmd.comp_dest;
            ihv_ff      <= init_vec;
            wv_ff       <= init_vec;
         end else if (comp_act_ff) begin
            if (comp_ld_ff) begin
               step_ff <= step_ff + 5'd1;
               if (step_wr) begin
                  for (int k = 0; k < 15; k++) win_ff[k] <= win_ff[k+1];
                  win_ff[15] <= load_word;
               end
               if (step_ff == 5'd16) comp_ld_ff <= 1'b0;
            end else if (!comp_fin_ff) begin
               wv_ff[0] <= t1 + t2;
               wv_ff[1] <= wv_ff[0];
               wv_ff[2] <= wv_ff[1];
               wv_ff[3] <= wv_ff[2];
               wv_ff[4] <= wv_ff[3] + t1;
               wv_ff[5] <= wv_ff[4];
               wv_ff[6] <= wv_ff[5];
               wv_ff[7] <= wv_ff[6];
               for (int k = 0; k < 15; k++) win_ff[k] <= win_ff[k+1];
               win_ff[15] <= sched_new;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) comp_fin_ff <= 1'b1;
            end else begin
               for (int k = 0; k < 8; k++) begin
                  if (dest_ff == dsha_pkg::DEST_CHAIN) hash_ff[k] <= ihv_ff[k] + wv_ff[k];
                  else tmp_ff[k] <= ihv_ff[k] + wv_ff[k];
               end
               comp_fin_ff <= 1'b0;
               comp_act_ff <= 1'b0;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= {tmp_ff[6], tmp_ff[7], tmp_ff[4], tmp_ff[5],
                    tmp_ff[2], tmp_ff[3], tmp_ff[0], tmp_ff[1]};
      end
   end

   assign rsp_data  = rsp_ff;
   assign sts.busy  = copy_act_ff | comp_act_ff;
   assign sts.fill  = fill_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dsha_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsha_ctrl
// Controller: accepts request beats, sequences context load, absorb, block
// compression, base save and finish compressions, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dsha_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,
   input  wire  [3:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  dsha_pkg::sts_type    sts,
   output dsha_pkg::cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_START = 12'b0000_0000_0010,
      S_LWAIT = 12'b0000_0000_0100,
      S_ABS   = 12'b0000_0000_1000,
      S_CWAIT = 12'b0000_0001_0000,
      S_SAVE  = 12'b0000_0010_0000,
      S_SWAIT = 12'b0000_0100_0000,
      S_FIN   = 12'b0000_1000_0000,
      S_F1W   = 12'b0001_0000_0000,
      S_F2W   = 12'b0010_0000_0000,
      S_F3W   = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic        in_msg_ff, in_msg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  typ_ff;
   logic        save_ff;
   logic        from_base_ff;
   logic [7:0]  data_ff;
   logic        accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      in_msg_in = in_msg_ff;
      cmd       = '0;
      cmd.data  = data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser[1:0] != dsha_pkg::REQ_RESERVED) state_in = S_START;
         end
         S_START: begin
            in_msg_in = 1'b1;
            if (in_msg_ff) begin
               state_in = S_ABS;
            end else if (from_base_ff) begin
               cmd.copy_start = 1'b1;
               cmd.copy_dir   = dsha_pkg::COPY_TO_RUN;
               state_in       = S_LWAIT;
            end else begin
               cmd.load_iv = 1'b1;
               state_in    = S_ABS;
            end
         end
         S_LWAIT: begin
            if (!sts.busy) state_in = S_ABS;
         end
         S_ABS: begin
            if (typ_ff != dsha_pkg::REQ_FINISH) begin
               cmd.absorb = 1'b1;
               if (sts.fill == dsha_pkg::FILL_LAST) begin
                  // block full: compress it into the chaining words
                  cmd.comp_start = 1'b1;
                  cmd.comp_src   = dsha_pkg::SRC_BUF;
                  cmd.comp_init  = dsha_pkg::INIT_CHAIN;
                  cmd.comp_dest  = dsha_pkg::DEST_CHAIN;
                  state_in       = S_CWAIT;
               end else begin
                  state_in = S_SAVE;
               end
            end else begin
               state_in = S_SAVE;
            end
         end
         S_CWAIT: begin
            if (!sts.busy) state_in = S_SAVE;
         end
         S_SAVE: begin
            if (save_ff) begin
               cmd.copy_start = 1'b1;
               cmd.copy_dir   = dsha_pkg::COPY_TO_BASE;
               state_in       = S_SWAIT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SWAIT: begin
            if (!sts.busy) state_in = S_FIN;
         end
         S_FIN: begin
            if (typ_ff == dsha_pkg::REQ_ABSORB) begin
               state_in = S_IDLE;
            end else begin
               in_msg_in      = 1'b0;
               cmd.comp_start = 1'b1;
               cmd.comp_src   = dsha_pkg::SRC_PAD1;
               cmd.comp_init  = dsha_pkg::INIT_CHAIN;
               cmd.comp_dest  = dsha_pkg::DEST_TMP;
               state_in       = S_F1W;
            end
         end
         S_F1W: begin
            if (!sts.busy) begin
               cmd.comp_start = 1'b1;
               cmd.comp_dest  = dsha_pkg::DEST_TMP;
               if (sts.fill > dsha_pkg::FILL_LEN_MAX) begin
                  cmd.comp_src  = dsha_pkg::SRC_PAD2;
                  cmd.comp_init = dsha_pkg::INIT_TMP;
                  state_in      = S_F2W;
               end else begin
                  cmd.comp_src  = dsha_pkg::SRC_DIG;
                  cmd.comp_init = dsha_pkg::INIT_IV;
                  state_in      = S_F3W;
               end
            end
         end
         S_F2W: begin
            if (!sts.busy) begin
               cmd.comp_start = 1'b1;
               cmd.comp_src   = dsha_pkg::SRC_DIG;
               cmd.comp_init  = dsha_pkg::INIT_IV;
               cmd.comp_dest  = dsha_pkg::DEST_TMP;
               state_in       = S_F3W;
            end
         end
         S_F3W: begin
            if (!sts.busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid: set on load, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request beat fields
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff      <= req_tdata;
         typ_ff       <= req_tuser[1:0];
         save_ff      <= req_tuser[2];
         from_base_ff <= req_tuser[3];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/double_sha256_with_midstate.sv -----
// A beat holds the request side until the controller is back in idle, so an absorb
// beat is taken only once the last is done; filling a block adds a compression
// (word loads, 64 rounds, a final add) and a base load or save adds a copy sweep. A
// finishing beat runs two or three finish compressions; rsp_tvalid rises once the
// result is loaded after the last. Synchronous active-high reset restores the IV in
// both contexts with zero fill and count and no open message; buffers keep data.
// ----------------------------------------------------------------------------
// double_sha256_with_midstate
// Double SHA-256 over a byte stream with a savable base midstate.
// ----------------------------------------------------------------------------
`default_nettype none

module double_sha256_with_midstate (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,    // data_byte
   input  wire  [3:0]   req_tuser,    // req_type[1:0], save_base, from_base
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [255:0] rsp_tdata     // digest_0, digest_1, digest_2, digest_3
);

   dsha_pkg::cmd_type cmd;
   dsha_pkg::sts_type sts;

   dsha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dsha_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- dv/tb_double_sha256_with_midstate.sv -----
// ----------------------------------------------------------------------------
// tb_double_sha256_with_midstate
// Self-checking bench for the double SHA-256 core. Byte beats go in on the
// request stream and digests are compared against a behavioral SHA-256d
// predictor that tracks the running context and the saved base midstate.
// A directed table comes first, then random messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_double_sha256_with_midstate;

   localparam int CYCLE_LIMIT = 2000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic [3:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;

   double_sha256_with_midstate uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // data_byte
      .req_tuser  (req_tuser),    // req_type[1:0], save_base, from_base
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // digest_0, digest_1, digest_2, digest_3
   );

   // one stimulus row; a nonzero golden digest is checked as typed,
   // digest_0 in the low 64 bits
   typedef struct {
      logic [7:0]   data;
      logic [1:0]   kind;
      logic         save;
      logic         from_base;
      logic [255:0] golden;
   } beat_row_type;

   // ---------------- predictor state ----------------
   logic [31:0] run_h [8];
   logic [7:0]  run_buf [64];
   logic [5:0]  run_fill;
   logic [60:0] run_cnt;
   logic [31:0] base_h [8];
   logic [7:0]  base_buf [64];
   logic [5:0]  base_fill;
   logic [60:0] base_cnt;
   logic        msg_open;

   logic [255:0] digest_queue [$];
   int errors;
   int digests_seen;
   int beats_sent;
   longint cycles;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one SHA-256 compression, block given as bytes
   function automatic void sha_block(ref logic [31:0] hv [8], input logic [7:0] blk [64]);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
      e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + dsha_pkg::K_TABLE[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
      hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
   endfunction

   // pad the running context, finish the first hash, hash the digest again
   function automatic logic [255:0] close_digest();
      logic [7:0]  blk [64];
      logic [7:0]  tail [64];
      logic [31:0] hv [8];
      logic [63:0] bits;
      logic [255:0] res;
      bits = {run_cnt, 3'b000};
      foreach (blk[i]) begin
         blk[i] = (i < run_fill) ? run_buf[i] : 8'h00;
         tail[i] = 8'h00;
      end
      blk[run_fill] = 8'h80;
      hv = run_h;
      if (run_fill <= dsha_pkg::FILL_LEN_MAX) begin
         for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
         sha_block(hv, blk);
      end else begin
         for (int i = 0; i < 8; i++) tail[63-i] = bits[8*i +: 8];
         sha_block(hv, blk);
         sha_block(hv, tail);
      end
      foreach (blk[i]) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++) blk[4*i+j] = hv[i][31-8*j -: 8];
      blk[32] = 8'h80;
      blk[62] = 8'h01;
      hv = dsha_pkg::IV_TABLE;
      sha_block(hv, blk);
      for (int i = 0; i < 8; i++) res[32*i +: 32] = hv[7-i];
      // digest_0 sits in the low 64 bits
      return {res[63:0], res[127:64], res[191:128], res[255:192]};
   endfunction

   // advance the predictor by one accepted beat; returns 1 when a digest is due
   function automatic bit track_beat(logic [7:0] data, logic [1:0] kind, logic save,
                                     logic from_base, output logic [255:0] dig);
      dig = '0;
      if (kind == dsha_pkg::REQ_RESERVED) return 0;
      if (!msg_open) begin
         if (from_base) begin
            run_h = base_h; run_buf = base_buf; run_fill = base_fill; run_cnt = base_cnt;
         end else begin
            run_h = dsha_pkg::IV_TABLE; run_fill = '0; run_cnt = '0;
         end
         msg_open = 1'b1;
      end
      if (kind != dsha_pkg::REQ_FINISH) begin
         run_buf[run_fill] = data;
         run_cnt = run_cnt + 61'd1;
         if (run_fill == dsha_pkg::FILL_LAST) sha_block(run_h, run_buf);
         run_fill = run_fill + 6'd1;
      end
      if (save) begin
         base_h = run_h; base_buf = run_buf; base_fill = run_fill; base_cnt = run_cnt;
      end
      if (kind == dsha_pkg::REQ_ABSORB) return 0;
      dig = close_digest();
      msg_open = 1'b0;
      return 1;
   endfunction

   task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // ---------------- clock, cycle guard ----------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_double_sha256_with_midstate failed");
            $finish;
         end
      end
   end

   // ---------------- result side: random stalls, check ----------------
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            digests_seen++;
            if (digest_queue.size() == 0)
               report_mismatch("unexpected digest", rsp_tdata, '0);
            else begin
               logic [255:0] want;
               want = digest_queue.pop_front();
               for (int k = 0; k < 4; k++)
                  if (rsp_tdata[64*k +: 64] !== want[64*k +: 64])
                     report_mismatch($sformatf("digest_%0d", k),
                                     rsp_tdata[64*k +: 64], want[64*k +: 64]);
            end
         end
         hold = $urandom_range(0, 99);
         if (hold >= 97) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 300)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (hold < 60) begin
            rsp_tready <= 1'b1;
         end else if (hold < 95) begin
            rsp_tready <= 1'b0;
         end
      end
   end

   // present one beat until accepted, then a random gap
   task automatic send_beat(beat_row_type row);
      logic [255:0] dig;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tuser  <= {row.from_base, row.save, row.kind};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (track_beat(row.data, row.kind, row.save, row.from_base, dig)) begin
         if (row.golden != '0 && row.golden !== dig)
            report_mismatch("predictor vs table", dig, row.golden);
         digest_queue.push_back(dig);
      end
      gap = $urandom_range(0, 99);
      gap = (gap < 50) ? 0 : (gap < 92) ? $urandom_range(1, 4) : $urandom_range(10, 200);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one random message; mostly short, occasionally long, base used sometimes
   task automatic send_message(int len, bit use_base, bit last_finish);
      beat_row_type r;
      for (int i = 0; i < len; i++) begin
         r.data = 8'($urandom_range(0, 255));
         r.kind = (i == len - 1 && last_finish) ? dsha_pkg::REQ_ABSORB_FINISH
                                                : dsha_pkg::REQ_ABSORB;
         r.save = ($urandom_range(0, 40) == 0);
         r.from_base = (i == 0) ? use_base : 1'($urandom_range(0, 1));
         r.golden = '0;
         if ($urandom_range(0, 60) == 0) begin
            // reserved code mixed in; must be ignored
            r.kind = dsha_pkg::REQ_RESERVED;
            send_beat(r);
            r.kind = (i == len - 1 && last_finish) ? dsha_pkg::REQ_ABSORB_FINISH
                                                   : dsha_pkg::REQ_ABSORB;
         end
         send_beat(r);
      end
      if (!last_finish) begin
         r.kind = dsha_pkg::REQ_FINISH; r.data = 8'($urandom_range(0, 255));
         r.save = 1'($urandom_range(0, 1)); r.from_base = 1'($urandom_range(0, 1));
         r.golden = '0;
         send_beat(r);
      end
   endtask

   // ---------------- stimulus ----------------
   initial begin
      beat_row_type table_rows [$];
      int lens [6];
      int len, tail_wait;
      errors = 0; digests_seen = 0; beats_sent = 0;
      msg_open = 1'b0;
      run_h = dsha_pkg::IV_TABLE; base_h = dsha_pkg::IV_TABLE;
      run_fill = '0; run_cnt = '0; base_fill = '0; base_cnt = '0;
      foreach (run_buf[i]) begin run_buf[i] = '0; base_buf[i] = '0; end
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, "abc", reserved code, base save/use, extremes
      table_rows = '{
         '{8'h00, dsha_pkg::REQ_FINISH, 1'b0, 1'b0,
           {64'h3e41983f5d4c9456, 64'h0381534545f55cf4,
            64'h0a8275058e299fcc, 64'h5df6e0e2761359d3}},
         '{8'hff, dsha_pkg::REQ_RESERVED, 1'b1, 1'b1, 256'h0},
         '{8'h61, dsha_pkg::REQ_ABSORB, 1'b0, 1'b0, 256'h0},
         '{8'h62, dsha_pkg::REQ_ABSORB, 1'b0, 1'b1, 256'h0},
         '{8'h63, dsha_pkg::REQ_ABSORB_FINISH, 1'b0, 1'b0, 256'h0},
         '{8'hff, dsha_pkg::REQ_ABSORB, 1'b1, 1'b0, 256'h0},
         '{8'h00, dsha_pkg::REQ_ABSORB_FINISH, 1'b1, 1'b0, 256'h0},
         '{8'h80, dsha_pkg::REQ_ABSORB_FINISH, 1'b0, 1'b1, 256'h0},
         '{8'h00, dsha_pkg::REQ_FINISH, 1'b0, 1'b1, 256'h0},
         '{8'h55, dsha_pkg::REQ_FINISH, 1'b1, 1'b0, 256'h0},
         '{8'haa, dsha_pkg::REQ_ABSORB_FINISH, 1'b0, 1'b1, 256'h0}
      };
      foreach (table_rows[i]) send_beat(table_rows[i]);

      // fill levels around the padding boundary
      lens = '{55, 56, 63, 64, 119, 120};
      foreach (lens[i]) send_message(lens[i], 1'b0, (i % 2) == 1);

      // random messages; now and then a first byte is saved as base, some start from the base
      while (beats_sent < 1050) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
         if ($urandom_range(0, 7) == 0) begin
            beat_row_type r;
            r.kind = dsha_pkg::REQ_ABSORB; r.save = 1'b1; r.golden = '0;
            r.from_base = 1'($urandom_range(0, 1)); r.data = 8'($urandom_range(0, 255));
            send_beat(r);
            send_message(len, 1'b0, 1'($urandom_range(0, 1)));
         end else if (len == 0)
            send_message(0, 1'($urandom_range(0, 1)), 1'b0);
         else
            send_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;

      wait (digest_queue.size() == 0);
      tail_wait = 0;
      while (tail_wait < 600) begin
         @(posedge clock);
         tail_wait++;
      end
      $display("covered %0d request beats and %0d digests, incl. base midstate reuse",
               beats_sent, digests_seen);
      $display("padding boundaries, empty messages and reserved codes were exercised");
      if (errors == 0)
         $display("tb_double_sha256_with_midstate passed");
      else
         $display("tb_double_sha256_with_midstate failed");
      $finish;
   end

endmodule
